// File: rtl/stn_pkg.sv
// Shared types, constants and the note period table of the square tone generator.
package stn_pkg;

    localparam int NOTE_COUNT_DEF = 64;
    localparam int ROM_DEPTH      = 64;
    localparam int ROM_AW         = 6;

    localparam logic [7:0]  VOL_LOUD         = 8'h7f;
    localparam logic [7:0]  VOL_SOFT         = 8'h40;
    localparam logic [15:0] SAMPLES_PER_UNIT = 16'd1000;

    // register indexes on the configuration port
    localparam logic REG_MIX_MODE = 1'b0;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [6:0] note_index;
        logic [5:0] length_units;
        logic [7:0] mix_in;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] sample;
        logic       last;
    } result_t;

    // floor(8000 / floor(440 * 2^((i-45)/12)))
    function automatic logic [7:0] period_lookup(input logic [ROM_AW-1:0] idx);
        logic [7:0] p;
        unique case (idx)
            6'd0:  p = 8'd250;  6'd1:  p = 8'd235;  6'd2:  p = 8'd222;  6'd3:  p = 8'd210;
            6'd4:  p = 8'd195;  6'd5:  p = 8'd186;  6'd6:  p = 8'd173;  6'd7:  p = 8'd166;
            6'd8:  p = 8'd156;  6'd9:  p = 8'd145;  6'd10: p = 8'd137;  6'd11: p = 8'd131;
            6'd12: p = 8'd123;  6'd13: p = 8'd115;  6'd14: p = 8'd109;  6'd15: p = 8'd103;
            6'd16: p = 8'd97;   6'd17: p = 8'd91;   6'd18: p = 8'd86;   6'd19: p = 8'd82;
            6'd20: p = 8'd77;   6'd21: p = 8'd72;   6'd22: p = 8'd68;   6'd23: p = 8'd65;
            6'd24: p = 8'd61;   6'd25: p = 8'd57;   6'd26: p = 8'd54;   6'd27: p = 8'd51;
            6'd28: p = 8'd48;   6'd29: p = 8'd45;   6'd30: p = 8'd43;   6'd31: p = 8'd41;
            6'd32: p = 8'd38;   6'd33: p = 8'd36;   6'd34: p = 8'd34;   6'd35: p = 8'd32;
            6'd36: p = 8'd30;   6'd37: p = 8'd28;   6'd38: p = 8'd27;   6'd39: p = 8'd25;
            6'd40: p = 8'd24;   6'd41: p = 8'd22;   6'd42: p = 8'd21;   6'd43: p = 8'd20;
            6'd44: p = 8'd19;   6'd45: p = 8'd18;   6'd46: p = 8'd17;   6'd47: p = 8'd16;
            6'd48: p = 8'd15;   6'd49: p = 8'd14;   6'd50: p = 8'd13;   6'd51: p = 8'd12;
            6'd52: p = 8'd12;   6'd53: p = 8'd11;   6'd54: p = 8'd10;   6'd55: p = 8'd10;
            6'd56: p = 8'd9;    6'd57: p = 8'd9;    6'd58: p = 8'd8;    6'd59: p = 8'd8;
            6'd60: p = 8'd7;    6'd61: p = 8'd7;    6'd62: p = 8'd6;    6'd63: p = 8'd6;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/stn_cfg.sv
// APB configuration register holding mix_mode.
module stn_cfg
    import stn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        mix_mode
);

    logic mix_mode_reg;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MIX_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            mix_mode_reg <= pwdata[0];
        end
    end

    // paddr[1:0] is the byte offset and is ignored
    assign prdata   = reg_sel ? {31'd0, mix_mode_reg} : 32'd0;
    assign mix_mode = mix_mode_reg;

endmodule

// File: rtl/stn_voice.sv
// Voice state and the one-pass sample computation for a registered item.
module stn_voice
    import stn_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    mix_mode,
    input  item_t   item,
    input  logic    advance,
    output result_t result
);

    logic [7:0]  period_reg,   period_next;
    logic [7:0]  phase_reg,    phase_next;
    logic [15:0] index_reg,    index_next;
    logic [15:0] duration_reg, duration_next;
    logic        active_reg,   active_next;

    logic        is_rest;
    logic [7:0]  volume;
    logic [7:0]  level;
    logic [8:0]  mix_sum;
    logic        is_last;
    logic [7:0]  phase_inc;

    always_comb begin
        is_rest = ({1'b0, item.note_index} >= 8'(NOTE_COUNT)) || item.note_index[6];

        volume  = (index_reg > {1'b0, duration_reg[15:1]}) ? VOL_SOFT : VOL_LOUD;
        level   = ((period_reg != 8'd0) && (phase_reg < {1'b0, period_reg[7:1]})) ?
                  volume : 8'd0;
        mix_sum = {1'b0, item.mix_in} + {1'b0, level};
        is_last = ({1'b0, index_reg} + 17'd1) == {1'b0, duration_reg};

        result.valid  = (item.action == ACT_TICK) && active_reg;
        result.sample = mix_mode ? mix_sum[8:1] : level;
        result.last   = is_last;

        phase_inc = phase_reg + 8'd1;

        period_next   = period_reg;
        phase_next    = phase_reg;
        index_next    = index_reg;
        duration_next = duration_reg;
        active_next   = active_reg;

        if (advance) begin
            if (item.action == ACT_LOAD) begin
                period_next   = is_rest ? 8'd0 : period_lookup(item.note_index[ROM_AW-1:0]);
                phase_next    = 8'd0;
                index_next    = 16'd0;
                duration_next = 16'(item.length_units) * SAMPLES_PER_UNIT;
                active_next   = (item.length_units != 6'd0);
            end else if (active_reg) begin
                if (period_reg != 8'd0) begin
                    phase_next = (phase_inc >= period_reg) ? 8'd0 : phase_inc;
                end
                if (is_last) begin
                    active_next = 1'b0;
                    index_next  = 16'd0;
                    phase_next  = 8'd0;
                end else begin
                    index_next = index_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= 8'd0;
            phase_reg    <= 8'd0;
            index_reg    <= 16'd0;
            duration_reg <= 16'd0;
            active_reg   <= 1'b0;
        end else begin
            period_reg   <= period_next;
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            duration_reg <= duration_next;
            active_reg   <= active_next;
        end
    end

endmodule

// File: rtl/square_tone_note_generator_core.sv
// Top level of the square tone note generator: input register, voice and result register.
//
//  channel  | direction | accepted when              | carries
//  ---------+-----------+----------------------------+-----------------------------------
//  s_axis   | in        | s_tvalid && s_tready       | tuser action, tdata note/len/mix
//  m_axis   | out       | m_tvalid && m_tready       | tdata sample, tlast end of note
//  apb      | in        | psel&penable&pwrite&pready | mix_mode at byte address 0
//
// One item per cycle while the result register is not stalled: an accepted item is held
// in the input register, is processed against the voice state in a single pass and, if it
// is a tick on an active note, lands in the result register once that register has room.
// Loads and idle ticks leave no result and never wait on m_tready.
// Reset is synchronous on aresetn low; it clears valids, the voice state and mix_mode.
// While the result register is full and not taken, a tick on an active note in the
// input register holds and s_tready drops; it rises again as soon as m_tready frees
// the register.
module square_tone_note_generator_core
    import stn_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [6:0] note_index, [12:7] length_units, [20:13] mix_in
    input  logic        s_tuser,   // [0] action: 0 load, 1 tick
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] sample
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    item_t      in_item_reg;
    logic       in_valid_reg;
    logic       m_valid_reg;
    logic [7:0] m_sample_reg;
    logic       m_last_reg;

    logic       mix_mode;
    logic       advance;
    logic       s_fire;
    result_t    result;

    stn_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mix_mode (mix_mode)
    );

    stn_voice #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_voice (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mix_mode (mix_mode),
        .item     (in_item_reg),
        .advance  (advance),
        .result   (result)
    );

    // Process the held item when it makes no result or the result register has room.
    assign advance  = in_valid_reg && (!result.valid || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture the payload only on accept; hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.action       <= action_t'(s_tuser);
            in_item_reg.note_index   <= s_tdata[6:0];
            in_item_reg.length_units <= s_tdata[12:7];
            in_item_reg.mix_in       <= s_tdata[20:13];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            m_sample_reg <= result.sample;
            m_last_reg   <= result.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/stn_checker.sv
// Port-level checks for the square tone note generator, bound to the top level.
module stn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [2:0]  paddr,
    input logic [31:0] prdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with the result register empty the input side never stalls
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // without mixing a sample is silence, loud or soft
    a_tone_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !paddr[2] && !prdata[0] |->
            (m_tdata == 8'h00) || (m_tdata == 8'h40) || (m_tdata == 8'h7f))
        else $error("unexpected tone level");

endmodule

bind square_tone_note_generator_core stn_checker u_stn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .paddr    (paddr),
    .prdata   (prdata)
);
